### src/tli_pkg.sv
package tli_pkg;

  localparam int TLI_DEPTH = 1024;

  localparam int POINT_COUNT_W = 11;
  localparam int STEP_SIZE_W   = 31;
  localparam int CFG_DATA_W    = 31;

  localparam logic [POINT_COUNT_W-1:0] POINT_COUNT_RST = 11'd2;
  localparam logic [STEP_SIZE_W-1:0]   STEP_SIZE_RST   = 31'd65536;

  typedef enum logic [0:0] {
    REG_POINT_COUNT = 1'b0,
    REG_STEP_SIZE   = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t         kind;
    logic [9:0]         entry_index;
    logic signed [31:0] entry_position;
    logic signed [31:0] entry_field;
    logic signed [31:0] query_position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] field_value;
    logic               out_of_range;
  } out_item_t;

endpackage

### src/table_linear_interpolator.sv
// Loads write one table entry at the accepting edge and give no result; they can run back to back.
// A query raises out_valid once its result is registered: the search reads the table once per cycle,
// then a multiply over the MUL0 and MUL1 states and a bit-serial divider follow. An out-of-range
// query goes from the first-entry check to the result; an overflowing quotient skips the divider.
// A new transaction is accepted in the cycle after the result is registered, even while the output
// register holds it. Synchronous active-low reset clears control state and resets configuration.
module table_linear_interpolator #(
  parameter int TABLE_DEPTH = tli_pkg::TLI_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tli_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tli_pkg::out_item_t           out_data,
  input  logic                         cfg_we,
  input  tli_pkg::cfg_reg_t            cfg_index,
  input  logic [tli_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tli_pkg::*;

  localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DIV_LEN = 34;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_LAST   = 11'b000_0000_0010,
    ST_FIRST  = 11'b000_0000_0100,
    ST_SEARCH = 11'b000_0000_1000,
    ST_PREP   = 11'b000_0001_0000,
    ST_MUL0   = 11'b000_0010_0000,
    ST_MUL1   = 11'b000_0100_0000,
    ST_DCHK   = 11'b000_1000_0000,
    ST_DIV    = 11'b001_0000_0000,
    ST_ADD    = 11'b010_0000_0000,
    ST_FIN    = 11'b100_0000_0000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [POINT_COUNT_W-1:0] point_count_r;
  logic [STEP_SIZE_W-1:0]   step_size_r;

  logic [63:0]              mem [TABLE_DEPTH];
  logic [63:0]              mem_q_r;
  logic [AW-1:0]            rd_addr;
  logic                     mem_we;

  logic signed [31:0]       q_r, plast_r, p_r, v0_r, v1_r, res_r;
  logic [AW-1:0]            n_last_r, idx_r;
  logic [STEP_SIZE_W-1:0]   d_r;
  logic                     oor_r;
  logic [32:0]              a_r, b_r;
  logic                     neg_r;
  logic [65:0]              prod_r;
  logic [30:0]              rem_r;
  logic [5:0]               cnt_r;
  logic [34:0]              mag_r;

  logic                     out_valid_r;
  out_item_t                out_data_r;

  logic signed [31:0]       mem_p, mem_v;
  logic [31:0]              n_eff;
  logic [AW-1:0]            n_last_w;
  logic [AW:0]              idx_inc;
  logic signed [32:0]       dv, dx;
  logic [49:0]              pp_lo;
  logic [48:0]              pp_hi;
  logic [31:0]              rem_sh;
  logic                     qbit;
  logic signed [35:0]       sum;
  logic                     in_acc, out_free;

  assign mem_p = mem_q_r[63:32];
  assign mem_v = mem_q_r[31:0];

  always_comb begin
    if (32'(point_count_r) < 32'd2) begin
      n_eff = 32'd2;
    end else if (32'(point_count_r) > 32'(TABLE_DEPTH)) begin
      n_eff = 32'(TABLE_DEPTH);
    end else begin
      n_eff = 32'(point_count_r);
    end
    n_last_w = AW'(n_eff - 32'd1);
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign mem_we   = in_acc && (in_data.kind == KIND_LOAD) &&
                    (32'(in_data.entry_index) < 32'(TABLE_DEPTH));
  assign idx_inc  = (AW+1)'(idx_r) + (AW+1)'(1);

  always_comb begin
    case (state_r)
      ST_IDLE:   rd_addr = n_last_w;
      ST_LAST:   rd_addr = '0;
      ST_FIRST:  rd_addr = AW'(1);
      ST_SEARCH: rd_addr = AW'(idx_inc + (AW+1)'(1));
      default:   rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(in_data.entry_index)] <= {in_data.entry_position, in_data.entry_field};
    end
    mem_q_r <= mem[rd_addr];
  end

  assign dv     = 33'(v1_r) - 33'(v0_r);
  assign dx     = 33'(q_r) - 33'(p_r);
  assign pp_lo  = a_r * b_r[16:0];
  assign pp_hi  = a_r * b_r[32:17];
  assign rem_sh = {rem_r, prod_r[33]};
  assign qbit   = (rem_sh >= {1'b0, d_r});
  assign sum    = neg_r ? (36'(v0_r) - 36'({1'b0, mag_r}))
                        : (36'(v0_r) + 36'({1'b0, mag_r}));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.kind == KIND_QUERY)) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST:  state_nxt = ST_FIRST;
      ST_FIRST: begin
        if ((q_r < mem_p) || (q_r >= plast_r)) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!((idx_inc != (AW+1)'(n_last_r)) && (mem_p <= q_r))) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: state_nxt = ST_MUL0;
      ST_MUL0: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_DCHK;
      ST_DCHK: begin
        if (prod_r[65:34] >= {1'b0, d_r}) begin
          state_nxt = ST_ADD;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == 6'(DIV_LEN - 1)) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      point_count_r <= POINT_COUNT_RST;
      step_size_r   <= STEP_SIZE_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_POINT_COUNT: point_count_r <= cfg_wdata[POINT_COUNT_W-1:0];
          REG_STEP_SIZE:   step_size_r   <= cfg_wdata[STEP_SIZE_W-1:0];
          default: ;
        endcase
      end
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        q_r      <= in_data.query_position;
        n_last_r <= n_last_w;
        d_r      <= (step_size_r == '0) ? STEP_SIZE_W'(1) : step_size_r;
        oor_r    <= 1'b0;
      end
      ST_LAST: plast_r <= mem_p;
      ST_FIRST: begin
        p_r   <= mem_p;
        v0_r  <= mem_v;
        idx_r <= '0;
        if ((q_r < mem_p) || (q_r >= plast_r)) begin
          oor_r <= 1'b1;
          res_r <= '0;
        end
      end
      ST_SEARCH: begin
        if ((idx_inc != (AW+1)'(n_last_r)) && (mem_p <= q_r)) begin
          idx_r <= AW'(idx_inc);
          p_r   <= mem_p;
          v0_r  <= mem_v;
        end else begin
          v1_r <= mem_v;
        end
      end
      ST_PREP: begin
        a_r   <= dv[32] ? (~dv + 33'd1) : dv;
        b_r   <= dx[32] ? (~dx + 33'd1) : dx;
        neg_r <= dv[32] ^ dx[32];
      end
      ST_MUL0: prod_r <= 66'(pp_lo);
      ST_MUL1: prod_r <= prod_r + (66'(pp_hi) << 17);
      ST_DCHK: begin
        rem_r <= prod_r[64:34];
        cnt_r <= '0;
        mag_r <= 35'h4_0000_0000;
      end
      ST_DIV: begin
        rem_r  <= qbit ? 31'(rem_sh - {1'b0, d_r}) : rem_sh[30:0];
        prod_r <= {prod_r[65:34], prod_r[32:0], qbit};
        cnt_r  <= cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_LEN - 1)) begin
          mag_r <= {1'b0, prod_r[32:0], qbit};
        end
      end
      ST_ADD: begin
        if (sum > 36'sd2147483647) begin
          res_r <= 32'sh7fff_ffff;
        end else if (sum < -36'sd2147483648) begin
          res_r <= 32'sh8000_0000;
        end else begin
          res_r <= sum[31:0];
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_data_r.field_value  <= res_r;
          out_data_r.out_of_range <= oor_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.out_of_range) |-> (out_data_r.field_value == 32'sd0))
    else $error("out-of-range result carries a nonzero value");

  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> ((AW+1)'(idx_r) < (AW+1)'(n_last_r)))
    else $error("segment search ran past the last entry in use");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (({1'b0, rem_r} < {1'b0, d_r}) && (cnt_r < 6'(DIV_LEN))))
    else $error("divider remainder or step count out of bounds");

  a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FIN) && out_free) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("finished query did not reach the output register");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != ST_IDLE) && (state_r != ST_FIN)) |=> !$past(in_acc))
    else $error("transaction accepted while a query was in progress");

endmodule
